FILE: design/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, constants and the column LFSR step for the CRC-10 frame
// checker.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int CHECK_BITS   = 10;
    localparam int DATA_BITS    = 27;
    localparam int FRAME_LENGTH = 38;

    localparam int DATA_BIT  = 0;   // data bit position in a sample
    localparam int START_BIT = 1;   // frame start marker position

    localparam logic [CHECK_BITS-1:0] REM_INIT  = 10'h393;
    localparam logic [CHECK_BITS-1:0] COL_INIT  = 10'h36E;
    localparam logic [CHECK_BITS-1:0] LFSR_TAPS = 10'h225;

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } state_t;

    // one step of the column LFSR: shift right, fold taps on the bit shifted out
    function automatic logic [CHECK_BITS-1:0] lfsr_step(input logic [CHECK_BITS-1:0] col);
        logic [CHECK_BITS-1:0] shifted;
        shifted = col >> 1;
        return col[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

endpackage

FILE: design/frc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_in_if
// Sample stream channel: one stream byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frc_in_if;
    logic                          valid;
    logic                          ready;
    logic [frc_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: design/frc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_out_if
// Checked frame channel: one frame byte plus status per word.
// ----------------------------------------------------------------------------
interface frc_out_if;
    logic                          valid;
    logic                          ready;
    logic [frc_pkg::SAMPLE_W-1:0]  out_sample;
    logic                          crc_ok;
    logic                          frame_last;

    modport source (output valid, output out_sample, output crc_ok, output frame_last,
                    input ready);
    modport sink   (input valid, input out_sample, input crc_ok, input frame_last,
                    output ready);
endinterface

FILE: design/frc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module frc_ram #(
    parameter int WIDTH = frc_pkg::SAMPLE_W,
    parameter int DEPTH = frc_pkg::FRAME_LENGTH
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/frame_crc10_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_crc10_checker
// Hunts for a frame start marker, stores a frame of bit-per-byte samples,
// runs the CRC-10 column LFSR one data bit per word, and replays the frame
// with its check result.
// ----------------------------------------------------------------------------
// Fill: one word per cycle while hunting or inside a frame; the CRC state
//   advances one bit per accepted data-field word.
// Drain: each word passes through the RAM read register and the output
//   register, one word per cycle while the receiver is ready; input is held off
//   for the FRAME_LENGTH drain reads, since the frame store is a single RAM.
// Reset: control cleared, block hunts for a marker; the frame store is not
//   cleared (each entry is written before it is read).
module frame_crc10_checker #(
    parameter int FRAME_LENGTH = frc_pkg::FRAME_LENGTH
) (
    input  logic            clk,
    input  logic            rst_n,
    frc_in_if.sink          samples,
    frc_out_if.source       frames
);

    localparam int AW = $clog2(FRAME_LENGTH);
    localparam int CW = frc_pkg::CHECK_BITS;
    localparam int SW = frc_pkg::SAMPLE_W;
    localparam logic [AW-1:0] LAST_POS = AW'(FRAME_LENGTH - 1);

    frc_pkg::state_t   state_reg, state_next;
    logic              in_frame_reg, in_frame_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     chk_reg, chk_next;
    logic              ok_reg, ok_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              q_valid_reg, q_valid_next;
    logic              q_ok_reg;
    logic              q_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     out_sample_reg;
    logic              out_ok_reg;
    logic              out_last_reg;

    logic              acc;
    logic              take;
    logic              data_bit;
    logic [AW-1:0]     idx;
    logic [CW-1:0]     rem_base, col_base, chk_base, col_step;
    logic              frame_end;
    logic              rd_en;
    logic              out_load;
    logic [SW-1:0]     q_data;

    // ---------------- fill side ----------------
    assign acc      = samples.valid && samples.ready;
    assign take     = acc && (in_frame_reg || samples.sample[frc_pkg::START_BIT]);
    assign data_bit = samples.sample[frc_pkg::DATA_BIT];

    // a start marker reloads the CRC state before its byte is absorbed
    assign idx      = in_frame_reg ? pos_reg : '0;
    assign rem_base = in_frame_reg ? rem_reg : frc_pkg::REM_INIT;
    assign col_base = in_frame_reg ? col_reg : frc_pkg::COL_INIT;
    assign chk_base = in_frame_reg ? chk_reg : '0;
    assign col_step = frc_pkg::lfsr_step(col_base);

    assign frame_end = take && (idx == LAST_POS);

    always_comb
    begin
        rem_next      = rem_reg;
        col_next      = col_reg;
        chk_next      = chk_reg;
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        ok_next       = ok_reg;
        if (take)
        begin
            rem_next = rem_base;
            col_next = col_base;
            chk_next = chk_base;
            if (int'(idx) < frc_pkg::DATA_BITS)
            begin
                col_next = col_step;
                rem_next = data_bit ? (rem_base ^ col_step) : rem_base;
            end
            else if (int'(idx) < frc_pkg::DATA_BITS + CW)
            begin
                chk_next = {chk_base[CW-2:0], ~data_bit};
            end
            if (frame_end)
            begin
                pos_next      = '0;
                in_frame_next = 1'b0;
                ok_next       = (chk_next == rem_next);
            end
            else
            begin
                pos_next      = idx + AW'(1);
                in_frame_next = 1'b1;
            end
        end
    end

    // ---------------- control FSM ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frc_pkg::S_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        rd_en         = 1'b0;
        rd_addr_next  = rd_addr_reg;
        case (state_reg)
            frc_pkg::S_FILL:
            begin
                samples.ready = 1'b1;
                if (frame_end)
                begin
                    state_next   = frc_pkg::S_DRAIN;
                    rd_addr_next = '0;
                end
            end
            frc_pkg::S_DRAIN:
            begin
                rd_en = !q_valid_reg || out_load;
                if (rd_en)
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                    if (rd_addr_reg == LAST_POS)
                    begin
                        state_next = frc_pkg::S_FILL;
                    end
                end
            end
            default:
            begin
                state_next = frc_pkg::S_FILL;
            end
        endcase
    end

    // ---------------- frame store ----------------
    frc_ram #(
        .WIDTH (SW),
        .DEPTH (FRAME_LENGTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (take),
        .wr_addr (idx),
        .wr_data (samples.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (q_data)
    );

    // ---------------- drain pipeline ----------------
    assign out_load       = q_valid_reg && (!out_valid_reg || frames.ready);
    assign q_valid_next   = rd_en ? 1'b1 : (out_load ? 1'b0 : q_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (frames.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            rem_reg       <= frc_pkg::REM_INIT;
            col_reg       <= frc_pkg::COL_INIT;
            chk_reg       <= '0;
            ok_reg        <= 1'b0;
            rd_addr_reg   <= '0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            col_reg       <= col_next;
            chk_reg       <= chk_next;
            ok_reg        <= ok_next;
            rd_addr_reg   <= rd_addr_next;
            q_valid_reg   <= q_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: status rides along with the read it belongs to
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_ok_reg   <= ok_reg;
            q_last_reg <= (rd_addr_reg == LAST_POS);
        end
        if (out_load)
        begin
            out_sample_reg <= q_ok_reg ? q_data : {{(SW-1){1'b0}}, q_data[frc_pkg::DATA_BIT]};
            out_ok_reg     <= q_ok_reg;
            out_last_reg   <= q_last_reg;
        end
    end

    assign frames.valid      = out_valid_reg;
    assign frames.out_sample = out_sample_reg;
    assign frames.crc_ok     = out_ok_reg;
    assign frames.frame_last = out_last_reg;

    // ---------------- assertions ----------------
    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frc_pkg::S_DRAIN) |-> !take)
        else $error("frame store written during drain");

    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (int'(rd_addr_reg) < FRAME_LENGTH))
        else $error("drain read beyond frame store");

    a_frame_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (state_reg == frc_pkg::S_DRAIN) && !in_frame_reg)
        else $error("frame end did not start drain");

    a_fail_masks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_sample_reg[SW-1:1] == '0))
        else $error("failed frame word not reduced to data bit");

endmodule

FILE: tb/sv/crc10_frame_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc10_frame_monitor
// Watches both channels of the CRC-10 frame checker. It tracks frames and the
// CRC state itself, queues the frame words that each completed frame must
// replay, and compares every accepted output word with them.
// ----------------------------------------------------------------------------
module crc10_frame_monitor (
    input  logic  clk,
    input  logic  rst_n,
    frc_in_if     samples,
    frc_out_if    frames,
    output int    errors,
    output int    backlog
);

    typedef struct packed {
        logic [frc_pkg::SAMPLE_W-1:0] sample;
        logic                         crc_ok;
        logic                         last;
    } frame_word_t;

    frame_word_t                       replay_q[$];
    logic                              in_frame;
    int                                frame_pos;
    logic [frc_pkg::CHECK_BITS-1:0]    crc_rem;
    logic [frc_pkg::CHECK_BITS-1:0]    col_word;
    logic [frc_pkg::CHECK_BITS-1:0]    rx_check;
    logic [frc_pkg::SAMPLE_W-1:0]      frame_mem [frc_pkg::FRAME_LENGTH];
    int                                err_cnt = 0;

    assign errors  = err_cnt;
    assign backlog = replay_q.size();

    // Advance the frame tracker by one accepted stream byte; on frame end
    // queue the whole replay.
    task automatic track_byte(input logic [frc_pkg::SAMPLE_W-1:0] b);
        logic        pass;
        frame_word_t w;
        if (!in_frame)
        begin
            if (!b[frc_pkg::START_BIT])
                return;
            in_frame  = 1'b1;
            frame_pos = 0;
            crc_rem   = frc_pkg::REM_INIT;
            col_word  = frc_pkg::COL_INIT;
            rx_check  = '0;
        end
        frame_mem[frame_pos] = b;
        if (frame_pos < frc_pkg::DATA_BITS)
        begin
            col_word = {1'b0, col_word[frc_pkg::CHECK_BITS-1:1]}
                       ^ (col_word[0] ? frc_pkg::LFSR_TAPS : '0);
            if (b[frc_pkg::DATA_BIT])
                crc_rem = crc_rem ^ col_word;
        end
        else if (frame_pos < frc_pkg::DATA_BITS + frc_pkg::CHECK_BITS)
        begin
            // check arrives inverted, MSB first
            rx_check = {rx_check[frc_pkg::CHECK_BITS-2:0], ~b[frc_pkg::DATA_BIT]};
        end
        frame_pos++;
        if (frame_pos == frc_pkg::FRAME_LENGTH)
        begin
            pass = (rx_check == crc_rem);
            for (int k = 0; k < frc_pkg::FRAME_LENGTH; k++)
            begin
                w.sample = pass ? frame_mem[k]
                                : {{(frc_pkg::SAMPLE_W-1){1'b0}}, frame_mem[k][frc_pkg::DATA_BIT]};
                w.crc_ok = pass;
                w.last   = (k == frc_pkg::FRAME_LENGTH - 1);
                replay_q.push_back(w);
            end
            in_frame  = 1'b0;
            frame_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t want;
        if (!rst_n)
        begin
            in_frame  = 1'b0;
            frame_pos = 0;
            crc_rem   = frc_pkg::REM_INIT;
            col_word  = frc_pkg::COL_INIT;
            rx_check  = '0;
        end
        else
        begin
            if (frames.valid && frames.ready)
            begin
                if (replay_q.size() == 0)
                begin
                    $error("unexpected output word: out_sample %h crc_ok %b frame_last %b",
                           frames.out_sample, frames.crc_ok, frames.frame_last);
                    err_cnt++;
                end
                else
                begin
                    want = replay_q.pop_front();
                    if (frames.out_sample !== want.sample)
                    begin
                        $error("out_sample: expected %h, got %h", want.sample, frames.out_sample);
                        err_cnt++;
                    end
                    if (frames.crc_ok !== want.crc_ok)
                    begin
                        $error("crc_ok: expected %b, got %b", want.crc_ok, frames.crc_ok);
                        err_cnt++;
                    end
                    if (frames.frame_last !== want.last)
                    begin
                        $error("frame_last: expected %b, got %b", want.last, frames.frame_last);
                        err_cnt++;
                    end
                end
            end
            if (samples.valid && samples.ready)
                track_byte(samples.sample);
        end
    end

endmodule

FILE: tb/sv/tb_frame_crc10_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_crc10_checker
// Feeds the CRC-10 frame checker with hunting noise and frames (good check,
// one flipped data or check bit, raw random bytes) under bursty input and a stalling
// output; the monitor predicts and compares every replayed word.
// ----------------------------------------------------------------------------
module tb_frame_crc10_checker;

    localparam int TARGET_WORDS = 430;
    localparam int CYCLE_LIMIT  = 200000;

    // frame kinds
    localparam int FR_GOOD = 0;
    localparam int FR_BAD  = 1;
    localparam int FR_RAW  = 2;
    // frame content
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    int   frame_words;
    int   rdy_mode;
    int   rdy_hold;
    int   cycle_cnt;
    logic [frc_pkg::SAMPLE_W-1:0] frame_bytes [frc_pkg::FRAME_LENGTH];

    frc_in_if  sample_ch();
    frc_out_if frame_ch();

    frame_crc10_checker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .frames  (frame_ch)
    );

    crc10_frame_monitor mon (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .frames  (frame_ch),
        .errors  (fail_count),
        .backlog (pending)
    );

    always #1 clk = ~clk;

    // receiver: modes of always ready, coin flip, and periodic stalls
    always @(posedge clk)
    begin
        if (rdy_hold == 0)
        begin
            rdy_mode <= $urandom_range(0, 2);
            rdy_hold <= $urandom_range(20, 80);
        end
        else
        begin
            rdy_hold <= rdy_hold - 1;
        end
        case (rdy_mode)
            0:       frame_ch.ready <= 1'b1;
            1:       frame_ch.ready <= 1'($urandom_range(0, 1));
            default: frame_ch.ready <= (rdy_hold % 12) > 4;
        endcase
    end

    // one word; sender idles between bursts
    task automatic send_word(input logic [frc_pkg::SAMPLE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 40);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= b;
        do @(posedge clk); while (!sample_ch.ready);
        burst_left--;
        frame_words++;
    endtask

    // bytes with no start marker, dropped while hunting
    task automatic send_noise(input int n);
        logic [frc_pkg::SAMPLE_W-1:0] b;
        repeat (n)
        begin
            b = frc_pkg::SAMPLE_W'($urandom);
            b[frc_pkg::START_BIT] = 1'b0;
            send_word(b);
        end
    endtask

    task automatic send_frame(input int kind, input int fill);
        logic [frc_pkg::CHECK_BITS-1:0] rem;
        logic [frc_pkg::CHECK_BITS-1:0] col;
        logic [5:0]                     hi;
        logic                           mk;
        logic                           d;
        int                             flip;
        for (int k = 0; k < frc_pkg::FRAME_LENGTH; k++)
        begin
            case (fill)
                FILL_ONES:
                begin
                    d = 1'b1; hi = 6'h3F; mk = 1'b1;
                end
                FILL_ZEROS:
                begin
                    d = 1'b0; hi = 6'h00; mk = (k == 0);
                end
                default:
                begin
                    d  = 1'($urandom_range(0, 1));
                    hi = 6'($urandom);
                    mk = (k == 0) || ($urandom_range(0, 5) == 0);
                end
            endcase
            frame_bytes[k] = {hi, mk, d};
        end
        if (kind != FR_RAW)
        begin
            rem = frc_pkg::REM_INIT;
            col = frc_pkg::COL_INIT;
            for (int k = 0; k < frc_pkg::DATA_BITS; k++)
            begin
                col = {1'b0, col[frc_pkg::CHECK_BITS-1:1]}
                      ^ (col[0] ? frc_pkg::LFSR_TAPS : '0);
                if (frame_bytes[k][frc_pkg::DATA_BIT])
                    rem = rem ^ col;
            end
            for (int i = 0; i < frc_pkg::CHECK_BITS; i++)
                if (frc_pkg::DATA_BITS + i < frc_pkg::FRAME_LENGTH)
                    frame_bytes[frc_pkg::DATA_BITS + i][frc_pkg::DATA_BIT] =
                        ~rem[frc_pkg::CHECK_BITS - 1 - i];
            if (kind == FR_BAD)
            begin
                flip = $urandom_range(0, frc_pkg::DATA_BITS + frc_pkg::CHECK_BITS - 1);
                frame_bytes[flip][frc_pkg::DATA_BIT] = ~frame_bytes[flip][frc_pkg::DATA_BIT];
            end
        end
        for (int k = 0; k < frc_pkg::FRAME_LENGTH; k++)
            send_word(frame_bytes[k]);
    endtask

    initial
    begin
        int r;
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        frame_ch.ready   = 1'b0;
        rdy_mode         = 0;
        rdy_hold         = 0;
        burst_left       = 0;
        frame_words      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hunting drops at the byte extremes
        send_word(8'h00);
        send_word(8'hFD);
        send_word(8'h01);
        send_word(8'hFC);
        // all-ones frame, marker on every byte; then a quiet frame right after
        send_frame(FR_GOOD, FILL_ONES);
        send_frame(FR_GOOD, FILL_ZEROS);

        while (frame_words + frc_pkg::FRAME_LENGTH <= TARGET_WORDS)
        begin
            if ($urandom_range(0, 2) != 0)
                send_noise($urandom_range(1, 4));
            r = $urandom_range(0, 9);
            if (r < 6)
                send_frame(FR_GOOD, FILL_RANDOM);
            else if (r < 8)
                send_frame(FR_BAD, FILL_RANDOM);
            else
                send_frame(FR_RAW, FILL_RANDOM);
        end
        sample_ch.valid <= 1'b0;

        // let the monitor queue the last frame before waiting on it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/frc_pkg.sv
design/frc_in_if.sv
design/frc_out_if.sv
design/frc_ram.sv
design/frame_crc10_checker.sv
tb/sv/crc10_frame_monitor.sv
tb/sv/tb_frame_crc10_checker.sv
